>>> hdl/sei_pkg.sv
// shared types and constants for the sinr estimation error injector
`timescale 1ns / 1ps

package sei_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_APPLY = 1'b1;

	localparam int DATA_W    = 16;
	localparam int CFG_W     = 5;
	localparam int ROW_W     = 4;
	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = 4;
	localparam int FRAC_SHIFT = 12;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_RD0    = 9'b000000010,
		ST_RDL    = 9'b000000100,
		ST_SCAN   = 9'b000001000,
		ST_MULP   = 9'b000010000,
		ST_DIV    = 9'b000100000,
		ST_INTERP = 9'b001000000,
		ST_MUL    = 9'b010000000,
		ST_FIN    = 9'b100000000
	} state_t;

	typedef struct packed {
		logic capture_in;
		logic write_row;
		logic save_prev;
		logic set_dev_row;
		logic load_interp;
		logic mul_slope;
		logic div_step;
		logic set_dev_interp;
		logic mul_err;
		logic emit_result;
		logic emit_zero;
	} dp_cmd_t;

	typedef struct packed {
		logic x_le_pt;
		logic x_ge_pt;
	} dp_status_t;

endpackage

>>> hdl/sinr_estimation_error_injector.sv
// top level of the sinr estimation error injector
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. A load request writes
// one grid row and returns a zero result with done in the next cycle; busy stays
// low, so loads can follow each other every cycle. An apply request holds busy
// until its result. An input at or below the first grid point, or at or above
// the last row in use, takes that row's deviation directly; an input that falls
// below row k is interpolated, and its wait grows with k. The time to the
// result is set by the table walk, which reads one row per cycle from the
// single read port, and by the 16-step serial divider for the slope. The
// result is valid on sinr_out and clipped for the one cycle that done is high;
// the receiver cannot stall it. Users must write entries_in_use through cfg_we
// and cfg_data only while no request is in progress; this is not enforced.
module sinr_estimation_error_injector #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic [sei_pkg::ROW_W-1:0]         row_index,
	input  logic signed [sei_pkg::DATA_W-1:0] grid_sinr,
	input  logic [sei_pkg::DATA_W-1:0]        grid_deviation,
	input  logic signed [sei_pkg::DATA_W-1:0] sinr_in,
	input  logic signed [sei_pkg::DATA_W-1:0] noise_sample,
	output logic                              done,
	output logic signed [sei_pkg::DATA_W-1:0] sinr_out,
	output logic                              clipped,
	input  logic                              cfg_we,
	input  logic [sei_pkg::CFG_W-1:0]         cfg_data
);
	import sei_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	dp_cmd_t       cmd;
	dp_status_t    status;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] last_idx;

	sei_ctrl #(
		.AW(AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.busy      (busy),
		.status    (status),
		.last_idx  (last_idx),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	sei_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.rd_addr        (rd_addr),
		.status         (status),
		.last_idx       (last_idx),
		.row_index      (row_index),
		.grid_sinr      (grid_sinr),
		.grid_deviation (grid_deviation),
		.sinr_in        (sinr_in),
		.noise_sample   (noise_sample),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.done           (done),
		.sinr_out       (sinr_out),
		.clipped        (clipped)
	);

endmodule

>>> hdl/sei_dp.sv
// datapath: grid table memory, interpolation, serial divider, error multiply and saturation
`timescale 1ns / 1ps

module sei_dp #(
	parameter int TABLE_DEPTH = 16,
	parameter int AW = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sei_pkg::dp_cmd_t              cmd,
	input  logic [AW-1:0]                 rd_addr,
	output sei_pkg::dp_status_t           status,
	output logic [AW-1:0]                 last_idx,
	input  logic [sei_pkg::ROW_W-1:0]     row_index,
	input  logic signed [sei_pkg::DATA_W-1:0] grid_sinr,
	input  logic [sei_pkg::DATA_W-1:0]    grid_deviation,
	input  logic signed [sei_pkg::DATA_W-1:0] sinr_in,
	input  logic signed [sei_pkg::DATA_W-1:0] noise_sample,
	input  logic                          cfg_we,
	input  logic [sei_pkg::CFG_W-1:0]     cfg_data,
	output logic                          done,
	output logic signed [sei_pkg::DATA_W-1:0] sinr_out,
	output logic                          clipped
);
	import sei_pkg::*;

	logic signed [DATA_W-1:0] pt_mem [TABLE_DEPTH];
	logic [DATA_W-1:0]        dev_mem [TABLE_DEPTH];

	logic [CFG_W-1:0]         entries_q;
	logic signed [DATA_W-1:0] rd_pt_q;
	logic [DATA_W-1:0]        rd_dev_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] z_q;
	logic signed [DATA_W-1:0] prev_pt_q;
	logic [DATA_W-1:0]        prev_dev_q;
	logic [DATA_W-1:0]        offs_q;
	logic [DATA_W-1:0]        span_q;
	logic [DATA_W-1:0]        dd_q;
	logic                     dec_q;
	logic [DATA_W-1:0]        rem_q;
	logic [DATA_W-1:0]        quo_q;
	logic [DATA_W-1:0]        dev_q;
	logic signed [2*DATA_W:0] eprod_q;
	logic                     done_q;
	logic signed [DATA_W-1:0] sinr_out_q;
	logic                     clipped_q;

	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic signed [DATA_W:0]   offs_w;
	logic signed [DATA_W:0]   span_w;
	logic [DATA_W:0]          trial_w;
	logic [DATA_W:0]          diff_w;
	logic signed [2*DATA_W:0] rnd_w;
	logic signed [2*DATA_W-FRAC_SHIFT:0] err_w;
	logic signed [2*DATA_W-FRAC_SHIFT+1:0] sum_w;
	logic signed [DATA_W-1:0] sat_w;
	logic                     clip_w;

	// row count clamped to 1..TABLE_DEPTH
	always_comb begin
		if (entries_q == '0) begin
			last_idx = '0;
		end else if (32'(entries_q) > TABLE_DEPTH) begin
			last_idx = AW'(TABLE_DEPTH - 1);
		end else begin
			last_idx = AW'(entries_q - CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= CFG_W'(1);
		end else if (cfg_we) begin
			entries_q <= cfg_data;
		end
	end

	assign wr_en   = cmd.write_row && (32'(row_index) < TABLE_DEPTH);
	assign wr_addr = AW'(row_index);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pt_mem[wr_addr]  <= grid_sinr;
			dev_mem[wr_addr] <= grid_deviation;
		end
		rd_pt_q  <= pt_mem[rd_addr];
		rd_dev_q <= dev_mem[rd_addr];
	end

	assign status.x_le_pt = (x_q <= rd_pt_q);
	assign status.x_ge_pt = (x_q >= rd_pt_q);

	assign offs_w  = {x_q[DATA_W-1], x_q} - {prev_pt_q[DATA_W-1], prev_pt_q};
	assign span_w  = {rd_pt_q[DATA_W-1], rd_pt_q} - {prev_pt_q[DATA_W-1], prev_pt_q};
	assign trial_w = {rem_q, quo_q[DATA_W-1]};
	assign diff_w  = trial_w - {1'b0, span_q};

	always_ff @(posedge clk) begin
		if (cmd.capture_in) begin
			x_q <= sinr_in;
			z_q <= noise_sample;
		end
		if (cmd.save_prev) begin
			prev_pt_q  <= rd_pt_q;
			prev_dev_q <= rd_dev_q;
		end
		if (cmd.load_interp) begin
			offs_q <= offs_w[DATA_W-1:0];
			span_q <= span_w[DATA_W-1:0];
			dec_q  <= (rd_dev_q < prev_dev_q);
			dd_q   <= (rd_dev_q >= prev_dev_q) ? (rd_dev_q - prev_dev_q)
			                                   : (prev_dev_q - rd_dev_q);
		end
		if (cmd.mul_slope) begin
			{rem_q, quo_q} <= offs_q * dd_q;
		end else if (cmd.div_step) begin
			if (trial_w >= {1'b0, span_q}) begin
				rem_q <= diff_w[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= trial_w[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
		if (cmd.set_dev_row) begin
			dev_q <= rd_dev_q;
		end else if (cmd.set_dev_interp) begin
			dev_q <= dec_q ? (prev_dev_q - quo_q) : (prev_dev_q + quo_q);
		end
		if (cmd.mul_err) begin
			eprod_q <= $signed({1'b0, dev_q}) * z_q;
		end
	end

	// round half up, then floor by 2^12
	assign rnd_w = eprod_q + (2*DATA_W+1)'(2048);
	assign err_w = rnd_w[2*DATA_W:FRAC_SHIFT];
	assign sum_w = (2*DATA_W-FRAC_SHIFT+2)'(x_q) + (2*DATA_W-FRAC_SHIFT+2)'(err_w);

	always_comb begin
		clip_w = 1'b0;
		sat_w  = sum_w[DATA_W-1:0];
		if (sum_w > (2*DATA_W-FRAC_SHIFT+2)'(32767)) begin
			sat_w  = 16'sh7fff;
			clip_w = 1'b1;
		end else if (sum_w < -(2*DATA_W-FRAC_SHIFT+2)'(32768)) begin
			sat_w  = 16'sh8000;
			clip_w = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_result || cmd.emit_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_zero) begin
			sinr_out_q <= '0;
			clipped_q  <= 1'b0;
		end else if (cmd.emit_result) begin
			sinr_out_q <= sat_w;
			clipped_q  <= clip_w;
		end
	end

	assign done     = done_q;
	assign sinr_out = sinr_out_q;
	assign clipped  = clipped_q;

endmodule

>>> hdl/sei_ctrl.sv
// controller: request sequencing, table walk and divider step count
`timescale 1ns / 1ps

module sei_ctrl #(
	parameter int AW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                operation,
	output logic                busy,
	input  sei_pkg::dp_status_t status,
	input  logic [AW-1:0]       last_idx,
	output sei_pkg::dp_cmd_t    cmd,
	output logic [AW-1:0]       rd_addr
);
	import sei_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    idx_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		rd_addr = '0;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (operation == OP_APPLY) begin
						cmd.capture_in = 1'b1;
						state_d        = ST_RD0;
					end else begin
						cmd.write_row = 1'b1;
						cmd.emit_zero = 1'b1;
					end
				end
			end
			ST_RD0: begin
				if (status.x_le_pt) begin
					cmd.set_dev_row = 1'b1;
					state_d         = ST_MUL;
				end else begin
					cmd.save_prev = 1'b1;
					rd_addr       = last_idx;
					state_d       = ST_RDL;
				end
			end
			ST_RDL: begin
				if (status.x_ge_pt) begin
					cmd.set_dev_row = 1'b1;
					state_d         = ST_MUL;
				end else begin
					idx_d   = AW'(1);
					rd_addr = AW'(1);
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!status.x_ge_pt) begin
					cmd.load_interp = 1'b1;
					state_d         = ST_MULP;
				end else begin
					cmd.save_prev = 1'b1;
					idx_d         = idx_q + AW'(1);
					rd_addr       = idx_q + AW'(1);
				end
			end
			ST_MULP: begin
				cmd.mul_slope = 1'b1;
				cnt_d         = '0;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_INTERP;
				end
			end
			ST_INTERP: begin
				cmd.set_dev_interp = 1'b1;
				state_d            = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_err = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				cmd.emit_result = 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
		end
	end

`ifndef SYNTHESIS
	a_apply_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_APPLY) |=> busy)
		else $error("apply request did not raise busy");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) |=> (state_q == ST_INTERP))
		else $error("divider did not finish after its step count");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= last_idx && idx_q != '0))
		else $error("table walk left the rows in use");
`endif

endmodule

>>> tb/sinr_estimation_error_injector_checker.sv
// checker for the sinr estimation error injector: tracks the grid table, predicts and compares
`timescale 1ns / 1ps

module sinr_estimation_error_injector_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              operation,
	input  logic [sei_pkg::ROW_W-1:0]         row_index,
	input  logic signed [sei_pkg::DATA_W-1:0] grid_sinr,
	input  logic [sei_pkg::DATA_W-1:0]        grid_deviation,
	input  logic signed [sei_pkg::DATA_W-1:0] sinr_in,
	input  logic signed [sei_pkg::DATA_W-1:0] noise_sample,
	input  logic                              done,
	input  logic signed [sei_pkg::DATA_W-1:0] sinr_out,
	input  logic                              clipped,
	input  logic                              cfg_we,
	input  logic [sei_pkg::CFG_W-1:0]         cfg_data,
	output int                                wrong_count,
	output int                                pending
);
	import sei_pkg::*;

	localparam int TBL_ROWS = 16;

	typedef struct packed {
		logic signed [DATA_W-1:0] sinr;
		logic                     clip;
	} outcome_t;

	logic signed [DATA_W-1:0] grid_pt [TBL_ROWS];
	logic [DATA_W-1:0]        grid_dev [TBL_ROWS];
	logic [CFG_W-1:0]         cfg_rows;
	outcome_t                 sinr_due [$];
	int                       result_idx;

	function automatic logic [DATA_W-1:0] deviation_at(input logic signed [DATA_W-1:0] x);
		int n;
		longint x0, x1, d0, d1, offs, span, mag;
		logic [DATA_W-1:0] r;
		n = (cfg_rows == 0) ? 1 : (cfg_rows > TBL_ROWS) ? TBL_ROWS : int'(cfg_rows);
		if (x <= grid_pt[0])
			return grid_dev[0];
		if (x >= grid_pt[n-1])
			return grid_dev[n-1];
		for (int k = 1; k < n; k++) begin
			if (x < grid_pt[k]) begin
				x0 = grid_pt[k-1];
				x1 = grid_pt[k];
				d0 = grid_dev[k-1];
				d1 = grid_dev[k];
				span = x1 - x0;
				offs = longint'(x) - x0;
				if (span == 0)
					return grid_dev[k-1];
				if (d1 >= d0) begin
					mag = offs * (d1 - d0) / span;
					r = DATA_W'(d0 + mag);
				end else begin
					mag = offs * (d0 - d1) / span;
					r = DATA_W'(d0 - mag);
				end
				return r;
			end
		end
		return grid_dev[n-1];
	endfunction

	function automatic outcome_t disturbed_sinr(input logic signed [DATA_W-1:0] x,
			input logic signed [DATA_W-1:0] z);
		outcome_t o;
		longint prod, sum;
		prod = longint'(deviation_at(x)) * longint'(z) + 2048;
		sum = longint'(x) + (prod >>> FRAC_SHIFT);
		o.clip = 1'b0;
		if (sum > 32767) begin
			sum = 32767;
			o.clip = 1'b1;
		end else if (sum < -32768) begin
			sum = -32768;
			o.clip = 1'b1;
		end
		o.sinr = sum[DATA_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t zero_res;
		if (!arst_n) begin
			sinr_due.delete();
			cfg_rows = CFG_W'(1);
			wrong_count = 0;
			result_idx = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (sinr_due.size() == 0) begin
					if (wrong_count < 10)
						$display("result %0d arrived with no request waiting: sinr_out %0d clipped %0b",
							result_idx, sinr_out, clipped);
					wrong_count++;
				end else begin
					want = sinr_due.pop_front();
					if (sinr_out !== want.sinr || clipped !== want.clip) begin
						if (wrong_count < 10)
							$display("result %0d wrong: expected sinr_out %0d clipped %0b, got %0d %0b",
								result_idx, want.sinr, want.clip, sinr_out, clipped);
						wrong_count++;
					end
				end
				result_idx++;
			end
			if (cfg_we)
				cfg_rows = cfg_data;
			if (start && !busy) begin
				if (operation == OP_LOAD) begin
					if (int'(row_index) < TBL_ROWS) begin
						grid_pt[row_index] = grid_sinr;
						grid_dev[row_index] = grid_deviation;
					end
					zero_res.sinr = '0;
					zero_res.clip = 1'b0;
					sinr_due.insert(sinr_due.size(), zero_res);
				end else begin
					sinr_due.insert(sinr_due.size(), disturbed_sinr(sinr_in, noise_sample));
				end
			end
			pending = sinr_due.size();
		end
	end

endmodule

>>> tb/sinr_estimation_error_injector_test.sv
// testbench top for the sinr estimation error injector: stimulus, reset and verdict
`timescale 1ns / 1ps

module sinr_estimation_error_injector_test;
	import sei_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     operation;
	logic [ROW_W-1:0]         row_index;
	logic signed [DATA_W-1:0] grid_sinr;
	logic [DATA_W-1:0]        grid_deviation;
	logic signed [DATA_W-1:0] sinr_in;
	logic signed [DATA_W-1:0] noise_sample;
	logic                     done;
	logic signed [DATA_W-1:0] sinr_out;
	logic                     clipped;
	logic                     cfg_we;
	logic [CFG_W-1:0]         cfg_data;
	int                       wrong_count;
	int                       pending;

	int tbl_pt [16];
	int rows_now;
	int gap_pct;
	bit quiet;
	int n_loads, n_applies, n_settings;

	sinr_estimation_error_injector dut (.*);

	sinr_estimation_error_injector_checker watch (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic send_request(input logic op, input logic [ROW_W-1:0] row,
			input logic [DATA_W-1:0] gs, input logic [DATA_W-1:0] gd,
			input logic [DATA_W-1:0] si, input logic [DATA_W-1:0] ns);
		start <= 1'b1;
		operation <= op;
		row_index <= row;
		grid_sinr <= gs;
		grid_deviation <= gd;
		sinr_in <= si;
		noise_sample <= ns;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_row(input int row, input int pt, input int dev);
		send_request(OP_LOAD, row[ROW_W-1:0], pt[15:0], dev[15:0], DATA_W'($urandom),
			DATA_W'($urandom));
		tbl_pt[row] = pt;
		n_loads++;
	endtask

	task automatic apply_sinr(input int x, input int z);
		send_request(OP_APPLY, ROW_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
			x[15:0], z[15:0]);
		n_applies++;
	endtask

	// config writes only with nothing in flight
	task automatic set_rows(input int v);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		rows_now = (v == 0) ? 1 : (v > 16) ? 16 : v;
		n_settings++;
	endtask

	task automatic gap();
		int n;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			n = $urandom_range(1, 7);
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	initial begin
		int ph, it, k, lo, hi, x, z, sel, base, maxstep, pt, dev, dmode, cfgv;
		bit unordered;
		start = 1'b0;
		operation = OP_LOAD;
		row_index = '0;
		grid_sinr = '0;
		grid_deviation = '0;
		sinr_in = '0;
		noise_sample = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		rows_now = 1;
		gap_pct = 0;
		quiet = 1'b0;
		n_loads = 0;
		n_applies = 0;
		n_settings = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single row after reset: extremes and saturation both ways
		load_row(0, -32768, 65535);
		apply_sinr(32767, 32767);
		apply_sinr(-32768, -32768);
		apply_sinr(0, 0);
		apply_sinr(-32768, 1);
		apply_sinr(100, -1);

		// three rows: below, on and between points, rising and falling segments
		set_rows(3);
		load_row(0, -512, 256);
		load_row(1, 0, 2048);
		load_row(2, 1280, 512);
		apply_sinr(-32768, 4096);
		apply_sinr(-512, -4096);
		apply_sinr(-300, 4096);
		apply_sinr(0, 12345);
		apply_sinr(700, -20000);
		apply_sinr(1280, 4096);
		apply_sinr(32767, -4096);
		// unordered table
		load_row(1, 2000, 65535);
		apply_sinr(1000, 32767);
		apply_sinr(1500, -32768);

		for (ph = 0; ph < 26; ph++) begin
			quiet = (ph >= 23);
			case ($urandom_range(0, 3))
				0: gap_pct = 0;
				1: gap_pct = 10;
				2: gap_pct = 30;
				default: gap_pct = 60;
			endcase
			case (ph)
				0: cfgv = 16;
				1: cfgv = 0;
				2: cfgv = 1;
				3: cfgv = 31;
				4: cfgv = 2;
				5: cfgv = 15;
				6: cfgv = 17;
				default: cfgv = $urandom_range(0, 31);
			endcase
			set_rows(cfgv);
			if (ph == 0 || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0: maxstep = 1;
					1: maxstep = 64;
					2: maxstep = 1024;
					default: maxstep = 4368;
				endcase
				base = -32768 + $urandom_range(0, 65535 - 15 * maxstep);
				unordered = ($urandom_range(0, 4) == 0);
				dmode = $urandom_range(0, 2);
				for (k = 0; k < 16; k++) begin
					if (unordered) begin
						pt = $urandom_range(0, 65535) - 32768;
					end else begin
						pt = base;
						base = base + $urandom_range(0, maxstep);
					end
					case (dmode)
						0: dev = $urandom_range(0, 65535);
						1: dev = $urandom_range(0, 1023);
						default: dev = $urandom_range(0, 1) ? 65535 : 0;
					endcase
					load_row(k, pt, dev);
					gap();
				end
			end
			for (it = 0; it < 44; it++) begin
				if ($urandom_range(0, 99) < 15) begin
					load_row($urandom_range(0, 15), $urandom_range(0, 65535) - 32768,
						$urandom_range(0, 65535));
				end else begin
					sel = $urandom_range(0, 99);
					if (sel < 60 && rows_now > 1) begin
						k = $urandom_range(1, rows_now - 1);
						lo = tbl_pt[k-1];
						hi = tbl_pt[k];
						if (hi > lo)
							x = lo + $urandom_range(0, hi - lo - 1);
						else
							x = lo;
					end else if (sel < 75) begin
						x = tbl_pt[$urandom_range(0, rows_now - 1)];
					end else if (sel < 85) begin
						x = $urandom_range(0, 1) ? 32767 : -32768;
					end else begin
						x = $urandom_range(0, 65535) - 32768;
					end
					sel = $urandom_range(0, 99);
					if (sel < 70)
						z = $urandom_range(0, 65535) - 32768;
					else if (sel < 85)
						z = $urandom_range(0, 8191) - 4096;
					else
						case ($urandom_range(0, 4))
							0: z = -32768;
							1: z = 32767;
							2: z = 0;
							3: z = 4096;
							default: z = -4096;
						endcase
					apply_sinr(x, z);
				end
				gap();
			end
		end

		start <= 1'b0;
		k = 0;
		while (pending != 0 && k < 2000) begin
			@(negedge clk);
			k++;
		end
		repeat (40) @(negedge clk);
		$display("covered %0d table loads and %0d lookups over %0d table-size settings",
			n_loads, n_applies, n_settings);
		$display("sizes 0, 1, 16 and 31 included, with saturation, grid hits and unordered tables");
		if (pending != 0)
			$display("%0d results never arrived", pending);
		if (wrong_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sinr_estimation_error_injector.f
hdl/sei_pkg.sv
hdl/sei_dp.sv
hdl/sei_ctrl.sv
hdl/sinr_estimation_error_injector.sv
tb/sinr_estimation_error_injector_checker.sv
tb/sinr_estimation_error_injector_test.sv
